/* rtl/tsed_pkg.sv */
// ============================================================================
// tsed_pkg
// Shared widths, register indexes, pipeline payload type and helper
// functions of the two-strain epidemic derivative pipeline.
// ============================================================================
package tsed_pkg;

    localparam int FRAC_W    = 32;   // Q1.31 fractions and imports
    localparam int RATE_W    = 32;   // Q16.16 rates
    localparam int FORCE_W   = 17;   // Q1.16 seasonal forcing, 1 .. 131071
    localparam int HALF_W    = 48;   // rate * fraction >> 16
    localparam int BETA_W    = 33;   // forced transmission rate
    localparam int LOAD_W    = 50;   // infectious load sum
    localparam int TERM_W    = 61;   // saturated product, at most 2^60
    localparam int DERIV_W   = 48;   // signed Q16.31 derivative
    localparam int NUM_COMP  = 9;
    localparam int CFG_IDX_W = 3;
    localparam int STAGES    = 10;

    localparam logic [TERM_W-1:0] TERM_CAP    = {1'b1, 60'b0};
    localparam logic [63:0]       ONE_Q30     = 64'd1073741824;
    localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;

    localparam logic [RATE_W-1:0] DEATH_RATE_RST = 32'd1311;
    localparam logic [RATE_W-1:0] UNITY_Q16      = 32'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEATH_RATE    = 3'd0,
        CFG_BETA_ONE      = 3'd1,
        CFG_BETA_TWO      = 3'd2,
        CFG_RECOVERY_RATE = 3'd3,
        CFG_CROSS_SUSC    = 3'd4,
        CFG_COINF_WEIGHT  = 3'd5,
        CFG_IMPORT_ONE    = 3'd6,
        CFG_IMPORT_TWO    = 3'd7
    } cfg_idx_t;

    typedef logic [FRAC_W-1:0] frac_t;
    typedef logic [HALF_W-1:0] half_t;
    typedef logic [TERM_W-1:0] term_t;

    typedef struct packed {
        frac_t [NUM_COMP-1:0] y;
        half_t                xy3;
        half_t                xy6;
        half_t                xy7;
        half_t [NUM_COMP-1:0] rec;
        half_t [NUM_COMP-1:0] dth;
        logic [BETA_W-1:0]    b1f;
        logic [BETA_W-1:0]    b2f;
        logic [LOAD_W-1:0]    l1;
        logic [LOAD_W-1:0]    l2;
        term_t                fa;
        term_t                fb;
    } pipe_t;

    // 32 x 32 product, drop the low 16 bits
    function automatic half_t mul_q16(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] full;
        full = {32'b0, a} * {32'b0, b};
        return full[63:16];
    endfunction

    function automatic logic signed [63:0] ext_term(input term_t t);
        return $signed({3'b0, t});
    endfunction

    function automatic logic signed [63:0] ext_half(input half_t h);
        return $signed({16'b0, h});
    endfunction

    function automatic logic [DERIV_W-1:0] sat_deriv(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd140737488355327;
        lo = -64'sd140737488355328;
        if (v > hi)
            return hi[DERIV_W-1:0];
        else if (v < lo)
            return lo[DERIV_W-1:0];
        return v[DERIV_W-1:0];
    endfunction

    // Taylor sums in Q2.30, used only to build the forcing ROM
    function automatic logic signed [63:0] cos_sum(input logic [63:0] t2);
        logic [63:0]        term;
        logic signed [63:0] sum;
        term = ONE_Q30;
        sum  = $signed(ONE_Q30);
        term = ((term * t2) >> 30) / 2;   sum = sum - $signed(term);
        term = ((term * t2) >> 30) / 12;  sum = sum + $signed(term);
        term = ((term * t2) >> 30) / 30;  sum = sum - $signed(term);
        term = ((term * t2) >> 30) / 56;  sum = sum + $signed(term);
        term = ((term * t2) >> 30) / 90;  sum = sum - $signed(term);
        term = ((term * t2) >> 30) / 132; sum = sum + $signed(term);
        term = ((term * t2) >> 30) / 182; sum = sum - $signed(term);
        term = ((term * t2) >> 30) / 240; sum = sum + $signed(term);
        return sum;
    endfunction

    function automatic logic signed [63:0] sin_sum(input logic [63:0] th,
                                                   input logic [63:0] t2);
        logic [63:0]        term;
        logic signed [63:0] sum;
        term = th;
        sum  = $signed(th);
        term = ((term * t2) >> 30) / 6;   sum = sum - $signed(term);
        term = ((term * t2) >> 30) / 20;  sum = sum + $signed(term);
        term = ((term * t2) >> 30) / 42;  sum = sum - $signed(term);
        term = ((term * t2) >> 30) / 72;  sum = sum + $signed(term);
        term = ((term * t2) >> 30) / 110; sum = sum - $signed(term);
        term = ((term * t2) >> 30) / 156; sum = sum + $signed(term);
        term = ((term * t2) >> 30) / 210; sum = sum - $signed(term);
        term = ((term * t2) >> 30) / 272; sum = sum + $signed(term);
        return sum;
    endfunction

    // ROM entry: 1 + e*cos(2*pi*turn) in Q1.16, turn in Q0.32
    function automatic logic [FORCE_W-1:0] forcing_entry(input logic [31:0] turn,
                                                         input logic [15:0] amp);
        logic [63:0]        rest;
        logic [63:0]        theta;
        logic [63:0]        theta2;
        logic signed [63:0] cv;
        logic signed [63:0] sv;
        logic signed [63:0] c;
        logic signed [63:0] p;
        rest   = {34'b0, turn[29:0]};
        theta  = (rest * HALF_PI_Q30) >> 30;
        theta2 = (theta * theta) >> 30;
        cv     = cos_sum(theta2);
        sv     = sin_sum(theta, theta2);
        case (turn[31:30])
            2'd0:    c = cv;
            2'd1:    c = -sv;
            2'd2:    c = -cv;
            default: c = sv;
        endcase
        if (c > $signed(ONE_Q30))
            c = $signed(ONE_Q30);
        if (c < -$signed(ONE_Q30))
            c = -$signed(ONE_Q30);
        p = $signed({48'b0, amp}) * c;
        p = (p + 64'sd70368744177664 + 64'sd536870912) >>> 30;
        return p[FORCE_W-1:0];
    endfunction

endpackage

/* rtl/tsed_forcing_rom.sv */
// ============================================================================
// tsed_forcing_rom
// Seasonal forcing lookup, contents fixed at build time, registered read.
// ============================================================================
module tsed_forcing_rom
    import tsed_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int AMPLITUDE = 6554
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [$clog2(DEPTH)-1:0] idx,
    output logic [FORCE_W-1:0]       forcing_val
);

    logic [FORCE_W-1:0] rom [DEPTH];
    logic [FORCE_W-1:0] forcing_reg;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_entry
        localparam logic [63:0] TURN = (64'(g) << 32) / DEPTH;
        assign rom[g] = forcing_entry(TURN[31:0], 16'(AMPLITUDE));
    end

    always_ff @(posedge clk)
    begin
        if (en)
            forcing_reg <= rom[idx];
    end

    assign forcing_val = forcing_reg;

endmodule

/* rtl/tsed_mul_sat.sv */
// ============================================================================
// tsed_mul_sat
// Two-stage wide multiply: split partial products, then sum, shift and
// saturate at 2^60.
// ============================================================================
module tsed_mul_sat
    import tsed_pkg::*;
#(
    parameter int A_W = 61,
    parameter int B_W = 32,
    parameter int SH  = 16
)
(
    input  logic           clk,
    input  logic           en_part,
    input  logic           en_sum,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output term_t          prod
);

    localparam int LO_W = A_W / 2;
    localparam int HI_W = A_W - LO_W;
    localparam int P_W  = A_W + B_W;

    logic [LO_W+B_W-1:0] lo_reg;
    logic [LO_W+B_W-1:0] lo_next;
    logic [HI_W+B_W-1:0] hi_reg;
    logic [HI_W+B_W-1:0] hi_next;
    logic [P_W-1:0]      full;
    logic [P_W-1:0]      shf;
    term_t               prod_reg;
    term_t               prod_next;

    assign lo_next = (LO_W+B_W)'(a[LO_W-1:0]) * (LO_W+B_W)'(b);
    assign hi_next = (HI_W+B_W)'(a[A_W-1:LO_W]) * (HI_W+B_W)'(b);

    always_comb
    begin
        full      = (P_W'(hi_reg) << LO_W) + P_W'(lo_reg);
        shf       = full >> SH;
        prod_next = (shf > P_W'(TERM_CAP)) ? TERM_CAP : shf[TERM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_part)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (en_sum)
            prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

/* rtl/two_strain_epidemic_derivative.sv */
// ============================================================================
// two_strain_epidemic_derivative
// Pipelined right-hand side of a seasonally forced two-strain SIR model.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    phase, frac_ss .. frac_rr
//   result    out        out_valid / out_stall  deriv_ss .. deriv_rr
//   config    in         cfg_we                 cfg_index, cfg_data
//
// Ten register stages; one transaction enters every cycle while not stalled.
// The depth is set by the chain forcing ROM -> forced rate -> force of
// infection -> cross-scaled force -> flow, each wide product taking two
// stages. Reset clears the valid bits and loads the register reset values.
// A stall on the result side holds only the stages that are full; bubbles
// keep closing behind it.
// ============================================================================
module two_strain_epidemic_derivative
    import tsed_pkg::*;
#(
    parameter int FORCING_TABLE_DEPTH = 1024,
    parameter int SEASONAL_AMPLITUDE  = 6554
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write port
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [31:0]                 cfg_data,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [15:0]                 phase,
    input  logic [FRAC_W-1:0]           frac_ss,
    input  logic [FRAC_W-1:0]           frac_is,
    input  logic [FRAC_W-1:0]           frac_si,
    input  logic [FRAC_W-1:0]           frac_ii,
    input  logic [FRAC_W-1:0]           frac_rs,
    input  logic [FRAC_W-1:0]           frac_sr,
    input  logic [FRAC_W-1:0]           frac_ri,
    input  logic [FRAC_W-1:0]           frac_ir,
    input  logic [FRAC_W-1:0]           frac_rr,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [DERIV_W-1:0]   deriv_ss,
    output logic signed [DERIV_W-1:0]   deriv_is,
    output logic signed [DERIV_W-1:0]   deriv_si,
    output logic signed [DERIV_W-1:0]   deriv_ii,
    output logic signed [DERIV_W-1:0]   deriv_rs,
    output logic signed [DERIV_W-1:0]   deriv_sr,
    output logic signed [DERIV_W-1:0]   deriv_ri,
    output logic signed [DERIV_W-1:0]   deriv_ir,
    output logic signed [DERIV_W-1:0]   deriv_rr
);

    localparam int IDX_W = $clog2(FORCING_TABLE_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [RATE_W-1:0] death_rate_reg;
    logic [RATE_W-1:0] beta_one_reg;
    logic [RATE_W-1:0] beta_two_reg;
    logic [RATE_W-1:0] recovery_rate_reg;
    logic [RATE_W-1:0] cross_susc_reg;
    logic [RATE_W-1:0] coinf_weight_reg;
    logic [FRAC_W-1:0] import_one_reg;
    logic [FRAC_W-1:0] import_two_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            death_rate_reg    <= DEATH_RATE_RST;
            beta_one_reg      <= '0;
            beta_two_reg      <= '0;
            recovery_rate_reg <= '0;
            cross_susc_reg    <= UNITY_Q16;
            coinf_weight_reg  <= UNITY_Q16;
            import_one_reg    <= '0;
            import_two_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DEATH_RATE:    death_rate_reg    <= cfg_data;
                CFG_BETA_ONE:      beta_one_reg      <= cfg_data;
                CFG_BETA_TWO:      beta_two_reg      <= cfg_data;
                CFG_RECOVERY_RATE: recovery_rate_reg <= cfg_data;
                CFG_CROSS_SUSC:    cross_susc_reg    <= cfg_data;
                CFG_COINF_WEIGHT:  coinf_weight_reg  <= cfg_data;
                CFG_IMPORT_ONE:    import_one_reg    <= cfg_data;
                CFG_IMPORT_TWO:    import_two_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage takes a new transaction when it is empty
    // or when the stage after it moves on.
    // ------------------------------------------------------------------
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] rdy;
    logic [STAGES-1:0] load;

    always_comb
    begin
        rdy[STAGES-1] = !vld_reg[STAGES-1] || !out_stall;
        for (int s = STAGES - 2; s >= 0; s--)
            rdy[s] = !vld_reg[s] || rdy[s+1];
        vld_next = {vld_reg[STAGES-2:0], in_valid};
        load     = rdy & vld_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                if (rdy[s])
                    vld_reg[s] <= vld_next[s];
            end
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = vld_reg[STAGES-1];

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    pipe_t              st_reg  [STAGES-1];
    pipe_t              st_next [STAGES-1];
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [32:0]        idx_prod;
    logic [FORCE_W-1:0] forcing_val;
    term_t              p1;
    term_t              p2;
    term_t              q1;
    term_t              q2;
    term_t              fa;
    term_t              fb;
    term_t              fc;
    term_t              fd;
    term_t              fg;
    term_t              fh;

    // table slot k = (phase * depth) >> 16, always below the depth
    assign idx_prod = {17'b0, phase} * 33'(FORCING_TABLE_DEPTH);
    assign idx_next = idx_prod[16 +: IDX_W];

    always_comb
    begin
        // stage 0: capture the state vector
        st_next[0]      = '0;
        st_next[0].y[0] = frac_ss;
        st_next[0].y[1] = frac_is;
        st_next[0].y[2] = frac_si;
        st_next[0].y[3] = frac_ii;
        st_next[0].y[4] = frac_rs;
        st_next[0].y[5] = frac_sr;
        st_next[0].y[6] = frac_ri;
        st_next[0].y[7] = frac_ir;
        st_next[0].y[8] = frac_rr;

        // stage 1: recovery and death terms, coinfection-weighted loads
        st_next[1]     = st_reg[0];
        st_next[1].xy3 = mul_q16(coinf_weight_reg, st_reg[0].y[3]);
        st_next[1].xy6 = mul_q16(coinf_weight_reg, st_reg[0].y[6]);
        st_next[1].xy7 = mul_q16(coinf_weight_reg, st_reg[0].y[7]);
        for (int i = 0; i < NUM_COMP; i++)
        begin
            st_next[1].rec[i] = mul_q16(recovery_rate_reg, st_reg[0].y[i]);
            st_next[1].dth[i] = mul_q16(death_rate_reg, st_reg[0].y[i]);
        end

        // stage 2: forced transmission rates and infectious loads
        st_next[2]     = st_reg[1];
        st_next[2].b1f = BETA_W'(mul_q16(beta_one_reg, 32'(forcing_val)));
        st_next[2].b2f = BETA_W'(mul_q16(beta_two_reg, 32'(forcing_val)));
        st_next[2].l1  = LOAD_W'(st_reg[1].y[1]) + LOAD_W'(import_one_reg)
                       + LOAD_W'(st_reg[1].xy3) + LOAD_W'(st_reg[1].xy7);
        st_next[2].l2  = LOAD_W'(st_reg[1].y[2]) + LOAD_W'(import_two_reg)
                       + LOAD_W'(st_reg[1].xy3) + LOAD_W'(st_reg[1].xy6);

        // stages 3 to 8: carry; the wide products run in their own units
        for (int s = 3; s < STAGES - 1; s++)
            st_next[s] = st_reg[s-1];
        st_next[7].fa = fa;
        st_next[7].fb = fb;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
            idx_reg <= idx_next;
        for (int s = 0; s < STAGES - 1; s++)
        begin
            if (load[s])
                st_reg[s] <= st_next[s];
        end
    end

    tsed_forcing_rom #(
        .DEPTH     (FORCING_TABLE_DEPTH),
        .AMPLITUDE (SEASONAL_AMPLITUDE)
    ) u_rom (
        .clk         (clk),
        .en          (load[1]),
        .idx         (idx_reg),
        .forcing_val (forcing_val)
    );

    // stages 3-4: forces of infection
    tsed_mul_sat #(.A_W(LOAD_W), .B_W(BETA_W), .SH(16)) u_p1 (
        .clk(clk), .en_part(load[3]), .en_sum(load[4]),
        .a(st_reg[2].l1), .b(st_reg[2].b1f), .prod(p1));
    tsed_mul_sat #(.A_W(LOAD_W), .B_W(BETA_W), .SH(16)) u_p2 (
        .clk(clk), .en_part(load[3]), .en_sum(load[4]),
        .a(st_reg[2].l2), .b(st_reg[2].b2f), .prod(p2));

    // stages 5-6: cross-scaled forces and infection of fully susceptibles
    tsed_mul_sat #(.A_W(TERM_W), .B_W(RATE_W), .SH(16)) u_q1 (
        .clk(clk), .en_part(load[5]), .en_sum(load[6]),
        .a(p1), .b(cross_susc_reg), .prod(q1));
    tsed_mul_sat #(.A_W(TERM_W), .B_W(RATE_W), .SH(16)) u_q2 (
        .clk(clk), .en_part(load[5]), .en_sum(load[6]),
        .a(p2), .b(cross_susc_reg), .prod(q2));
    tsed_mul_sat #(.A_W(TERM_W), .B_W(FRAC_W), .SH(31)) u_fa (
        .clk(clk), .en_part(load[5]), .en_sum(load[6]),
        .a(p1), .b(st_reg[4].y[0]), .prod(fa));
    tsed_mul_sat #(.A_W(TERM_W), .B_W(FRAC_W), .SH(31)) u_fb (
        .clk(clk), .en_part(load[5]), .en_sum(load[6]),
        .a(p2), .b(st_reg[4].y[0]), .prod(fb));

    // stages 7-8: infection of hosts marked by the other strain
    tsed_mul_sat #(.A_W(TERM_W), .B_W(FRAC_W), .SH(31)) u_fc (
        .clk(clk), .en_part(load[7]), .en_sum(load[8]),
        .a(q2), .b(st_reg[6].y[1]), .prod(fc));
    tsed_mul_sat #(.A_W(TERM_W), .B_W(FRAC_W), .SH(31)) u_fd (
        .clk(clk), .en_part(load[7]), .en_sum(load[8]),
        .a(q1), .b(st_reg[6].y[2]), .prod(fd));
    tsed_mul_sat #(.A_W(TERM_W), .B_W(FRAC_W), .SH(31)) u_fg (
        .clk(clk), .en_part(load[7]), .en_sum(load[8]),
        .a(q2), .b(st_reg[6].y[4]), .prod(fg));
    tsed_mul_sat #(.A_W(TERM_W), .B_W(FRAC_W), .SH(31)) u_fh (
        .clk(clk), .en_part(load[7]), .en_sum(load[8]),
        .a(q1), .b(st_reg[6].y[5]), .prod(fh));

    // ------------------------------------------------------------------
    // Stage 9: balance equations, saturate to 48 bits, hold for the sink
    // ------------------------------------------------------------------
    logic [DERIV_W-1:0] deriv_reg  [NUM_COMP];
    logic [DERIV_W-1:0] deriv_next [NUM_COMP];

    always_comb
    begin
        logic signed [63:0] birth;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] c;
        logic signed [63:0] d;
        logic signed [63:0] g;
        logic signed [63:0] h;
        logic signed [63:0] r [NUM_COMP];
        logic signed [63:0] m [NUM_COMP];
        birth = $signed({17'b0, death_rate_reg, 15'b0});
        a = ext_term(st_reg[8].fa);
        b = ext_term(st_reg[8].fb);
        c = ext_term(fc);
        d = ext_term(fd);
        g = ext_term(fg);
        h = ext_term(fh);
        for (int i = 0; i < NUM_COMP; i++)
        begin
            r[i] = ext_half(st_reg[8].rec[i]);
            m[i] = ext_half(st_reg[8].dth[i]);
        end
        deriv_next[0] = sat_deriv(birth - a - b - m[0]);
        deriv_next[1] = sat_deriv(a - c - r[1] - m[1]);
        deriv_next[2] = sat_deriv(b - d - r[2] - m[2]);
        deriv_next[3] = sat_deriv(c + d - (r[3] <<< 1) - m[3]);
        deriv_next[4] = sat_deriv(r[1] - g - m[4]);
        deriv_next[5] = sat_deriv(r[2] - h - m[5]);
        deriv_next[6] = sat_deriv(g - r[6] + r[3] - m[6]);
        deriv_next[7] = sat_deriv(h - r[7] + r[3] - m[7]);
        deriv_next[8] = sat_deriv(r[6] + r[7] - m[8]);
    end

    always_ff @(posedge clk)
    begin
        if (load[STAGES-1])
        begin
            for (int i = 0; i < NUM_COMP; i++)
                deriv_reg[i] <= deriv_next[i];
        end
    end

    assign deriv_ss = $signed(deriv_reg[0]);
    assign deriv_is = $signed(deriv_reg[1]);
    assign deriv_si = $signed(deriv_reg[2]);
    assign deriv_ii = $signed(deriv_reg[3]);
    assign deriv_rs = $signed(deriv_reg[4]);
    assign deriv_sr = $signed(deriv_reg[5]);
    assign deriv_ri = $signed(deriv_reg[6]);
    assign deriv_ir = $signed(deriv_reg[7]);
    assign deriv_rr = $signed(deriv_reg[8]);

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // a free sink never backs up into the source
    a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while result side is free");

    // pushing back on the source needs every stage full and a blocked sink
    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&vld_reg) && out_stall))
        else $error("input stalled with a bubble in the pipeline");

    // an empty pipeline with nothing arriving cannot produce a result
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg == '0) |=> !out_valid)
        else $error("result appeared from an empty pipeline");

endmodule
